// ===== hdl/sftd_pkg.sv =====
// shared constants and types for the smallest factor trial division block
package sftd_pkg;

  localparam int NUMBER_WIDTH = 63;
  localparam int FACTOR_WIDTH = 32;
  localparam int SUM_WIDTH    = 64;
  localparam int SQ_WIDTH     = 2 * FACTOR_WIDTH;
  localparam int DELTA_WIDTH  = FACTOR_WIDTH + 4;
  localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH + 1);
  localparam int FOLD_WIDTH   = 18;

  localparam int CAND_START   = 5;
  localparam int CAND_STEP    = 6;
  localparam int SQ_START     = CAND_START * CAND_START;
  localparam int DELTA_START  = 2 * CAND_STEP * CAND_START + CAND_STEP * CAND_STEP;
  localparam int DELTA_STEP   = 2 * CAND_STEP * CAND_STEP;

  // residues 0, 3, 6 and 9 of the final digit sum are multiples of three
  localparam logic [15:0] DIV3_HIT_MASK = 16'h0249;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_TWO,
    SEL_THREE,
    SEL_CAND,
    SEL_CAND2
  } fact_sel_t;

  typedef struct packed {
    logic      load;
    logic      div_start;
    fact_sel_t div_sel;
    logic      set_factor;
    fact_sel_t fact_sel;
    logic      step_cand;
    logic      write_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_small;
    logic n_even;
    logic n_div3;
    logic rem_done;
    logic rem_zero;
    logic sq_le_n;
    logic out_full;
  } dp_status_t;

endpackage

// ===== hdl/sftd_if.sv =====
// valid/ready channel interfaces for the number and result beats
interface sftd_in_if;
  logic        valid;
  logic        ready;
  logic [62:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface sftd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] smallest_factor;
  logic [63:0] running_sum;

  modport source (output valid, output smallest_factor, output running_sum, input ready);
  modport sink (input valid, input smallest_factor, input running_sum, output ready);
endinterface

// ===== hdl/sftd_rem.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
module sftd_rem
  import sftd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [FACTOR_WIDTH-1:0] divisor,
  output logic                    done,
  output logic                    rem_zero
);

  logic                    busy;
  logic [CNT_WIDTH-1:0]    cnt;
  logic [NUMBER_WIDTH-1:0] shreg;
  logic [FACTOR_WIDTH-1:0] dvs;
  logic [FACTOR_WIDTH-1:0] rem;
  logic [FACTOR_WIDTH:0]   trial;
  logic [FACTOR_WIDTH:0]   diff;
  logic [FACTOR_WIDTH-1:0] rem_next;

  always_comb begin
    trial = {rem, shreg[NUMBER_WIDTH-1]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      rem_next = diff[FACTOR_WIDTH-1:0];
    end else begin
      rem_next = trial[FACTOR_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(NUMBER_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_WIDTH'(1);
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[NUMBER_WIDTH-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign rem_zero = (rem == '0);

endmodule

// ===== hdl/sftd_dp.sv =====
// datapath: number, candidate wheel, running square, remainder unit, result register
module sftd_dp
  import sftd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  logic [62:0]             number,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FACTOR_WIDTH-1:0] out_factor,
  output logic [SUM_WIDTH-1:0]    out_sum
);

  logic [NUMBER_WIDTH-1:0] n;
  logic [FOLD_WIDTH-1:0]   n_fold;
  logic [9:0]              fold8;
  logic [5:0]              fold4;
  logic [3:0]              fold2;
  logic [FACTOR_WIDTH-1:0] cand;
  logic [FACTOR_WIDTH-1:0] cand2;
  logic [SQ_WIDTH-1:0]     sq;
  logic [DELTA_WIDTH-1:0]  delta;
  logic [FACTOR_WIDTH-1:0] factor;
  logic [SUM_WIDTH-1:0]    total;
  logic [FACTOR_WIDTH-1:0] divisor;
  logic [FACTOR_WIDTH-1:0] factor_next;
  logic                    rem_done;
  logic                    rem_zero;

  assign cand2 = cand + FACTOR_WIDTH'(2);

  function automatic logic [FACTOR_WIDTH-1:0] pick(
    input fact_sel_t               sel,
    input logic [FACTOR_WIDTH-1:0] c,
    input logic [FACTOR_WIDTH-1:0] c2
  );
    unique case (sel)
      SEL_ZERO:  pick = '0;
      SEL_TWO:   pick = FACTOR_WIDTH'(2);
      SEL_THREE: pick = FACTOR_WIDTH'(3);
      SEL_CAND:  pick = c;
      SEL_CAND2: pick = c2;
      default:   pick = '0;
    endcase
  endfunction

  // 2^16, 2^8, 2^4 and 2^2 are all 1 mod 3, so digit sums keep the residue
  function automatic logic [FOLD_WIDTH-1:0] fold16(input logic [63:0] v);
    fold16 = FOLD_WIDTH'(v[15:0]) + FOLD_WIDTH'(v[31:16]) + FOLD_WIDTH'(v[47:32])
           + FOLD_WIDTH'(v[63:48]);
  endfunction

  assign divisor     = pick(cmd.div_sel, cand, cand2);
  assign factor_next = pick(cmd.fact_sel, cand, cand2);

  sftd_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (n),
    .divisor  (divisor),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n      <= number[NUMBER_WIDTH-1:0];
      n_fold <= fold16(64'(number[NUMBER_WIDTH-1:0]));
      cand   <= FACTOR_WIDTH'(CAND_START);
      sq     <= SQ_WIDTH'(SQ_START);
      delta  <= DELTA_WIDTH'(DELTA_START);
    end else if (cmd.step_cand) begin
      cand  <= cand + FACTOR_WIDTH'(CAND_STEP);
      sq    <= sq + SQ_WIDTH'(delta);
      delta <= delta + DELTA_WIDTH'(DELTA_STEP);
    end
    if (cmd.set_factor) begin
      factor <= factor_next;
    end
    if (cmd.write_out) begin
      out_factor <= factor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      total     <= total + SUM_WIDTH'(factor);
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_sum = total;

  always_comb begin
    fold8 = 10'(n_fold[7:0]) + 10'(n_fold[15:8]) + 10'(n_fold[17:16]);
    fold4 = 6'(fold8[3:0]) + 6'(fold8[7:4]) + 6'(fold8[9:8]);
    fold2 = 4'(fold4[1:0]) + 4'(fold4[3:2]) + 4'(fold4[5:4]);
  end

  always_comb begin
    status.n_small  = (n <= NUMBER_WIDTH'(3));
    status.n_even   = ~n[0];
    status.n_div3   = DIV3_HIT_MASK[fold2];
    status.rem_done = rem_done;
    status.rem_zero = rem_zero;
    status.sq_le_n  = (sq <= SQ_WIDTH'(n));
    status.out_full = out_valid & ~out_ready;
  end

endmodule

// ===== hdl/sftd_ctrl.sv =====
// controller state machine sequencing the small-number checks and the wheel loop
module sftd_ctrl
  import sftd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TRIV  = 3'd1;
  localparam logic [2:0] S_LOOP  = 3'd3;
  localparam logic [2:0] S_WAITA = 3'd4;
  localparam logic [2:0] S_WAITB = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.div_start  = 1'b0;
    cmd.div_sel    = SEL_THREE;
    cmd.set_factor = 1'b0;
    cmd.fact_sel   = SEL_ZERO;
    cmd.step_cand  = 1'b0;
    cmd.write_out  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_TRIV;
        end
      end
      S_TRIV: begin
        if (status.n_small) begin
          cmd.set_factor = 1'b1;
          cmd.fact_sel   = SEL_ZERO;
          state_next     = S_DONE;
        end else if (status.n_even) begin
          cmd.set_factor = 1'b1;
          cmd.fact_sel   = SEL_TWO;
          state_next     = S_DONE;
        end else if (status.n_div3) begin
          cmd.set_factor = 1'b1;
          cmd.fact_sel   = SEL_THREE;
          state_next     = S_DONE;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        if (status.sq_le_n) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_CAND;
          state_next    = S_WAITA;
        end else begin
          cmd.set_factor = 1'b1;
          cmd.fact_sel   = SEL_ZERO;
          state_next     = S_DONE;
        end
      end
      S_WAITA: begin
        if (status.rem_done) begin
          if (status.rem_zero) begin
            cmd.set_factor = 1'b1;
            cmd.fact_sel   = SEL_CAND;
            state_next     = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = SEL_CAND2;
            state_next    = S_WAITB;
          end
        end
      end
      S_WAITB: begin
        if (status.rem_done) begin
          if (status.rem_zero) begin
            cmd.set_factor = 1'b1;
            cmd.fact_sel   = SEL_CAND2;
            state_next     = S_DONE;
          end else begin
            cmd.step_cand = 1'b1;
            state_next    = S_LOOP;
          end
        end
      end
      S_DONE: begin
        if (!status.out_full) begin
          cmd.write_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/smallest_factor_trial_division_top.sv =====
// top level of the smallest factor trial division block
//
//   channel  dir  beat fields
//   item     in   number (63b)
//   answer   out  smallest_factor (32b), running_sum (64b)
//
// one number at a time; 0..3, even numbers and multiples of three finish in the
// trivial checks without entering the wheel loop; each remainder by a wheel
// candidate is worked out in the bit-serial unit, candidates go as 6k-1/6k+1
// pairs, and there are about sqrt(n)/6 pairs at worst
// a new number is taken while the previous answer waits; answer stalls hold the
// block only when its result is ready to be written
// synchronous reset clears the controller, the output valid and the running sum
module smallest_factor_trial_division_top
  import sftd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  sftd_in_if.sink    item,
  sftd_out_if.source answer
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sftd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sftd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .number     (item.number),
    .out_valid  (answer.valid),
    .out_ready  (answer.ready),
    .out_factor (answer.smallest_factor),
    .out_sum    (answer.running_sum)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("number taken while another is in progress");

  a_sum_moves_with_result: assert property (@(posedge clk) disable iff (rst)
    !$stable(answer.running_sum) |-> answer.valid)
    else $error("running sum changed without a new result");

  a_even_factor_is_two: assert property (@(posedge clk) disable iff (rst)
    (answer.valid && !answer.smallest_factor[0] && answer.smallest_factor != 32'd0)
      |-> (answer.smallest_factor == 32'd2))
    else $error("even factor other than two");

endmodule
